// ----- rtl/vntp_pkg.sv -----
// Shared types and constants for the vertex normal and tangent packer.
// No dependencies; used by vntp_div_stage, the top level and the bench.
package vntp_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 14;

  localparam int unsigned COMP_W  = 16;
  localparam int unsigned TSUM_W  = 17;
  localparam int unsigned NUM_W   = 25;
  localparam int unsigned DEN_W   = TSUM_W + 1;
  localparam int unsigned OCT_Q_W = 7;
  localparam int unsigned DIV_STEPS = OCT_Q_W;

  localparam logic [9:0] NORM_BIAS = 10'd511;
  localparam logic [7:0] OCT_BIAS  = 8'd127;

  typedef struct packed {
    logic [29:0]        nbits;
    logic               flag;
    logic               tzero;
    logic               neg_u;
    logic               neg_v;
    logic [NUM_W-1:0]   rem_u;
    logic [NUM_W-1:0]   rem_v;
    logic [DEN_W-1:0]   den;
    logic [OCT_Q_W-1:0] q_u;
    logic [OCT_Q_W-1:0] q_v;
  } vntp_div_t;

endpackage

// ----- rtl/vntp_div_stage.sv -----
// One registered step of the restoring divider, both octahedral lanes.
// Depends on vntp_pkg.
module vntp_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  vntp_pkg::vntp_div_t data_i,
  output logic               vld_o,
  output vntp_pkg::vntp_div_t data_o
);
  import vntp_pkg::*;

  logic [NUM_W-1:0] dsh;
  logic [NUM_W:0]   sub_u, sub_v;
  vntp_div_t        data_d, data_q;
  logic             vld_q;

  always_comb begin
    dsh    = NUM_W'(data_i.den) << SHIFT;
    sub_u  = {1'b0, data_i.rem_u} - {1'b0, dsh};
    sub_v  = {1'b0, data_i.rem_v} - {1'b0, dsh};
    data_d = data_i;
    if (!sub_u[NUM_W]) begin
      data_d.rem_u      = sub_u[NUM_W-1:0];
      data_d.q_u[SHIFT] = 1'b1;
    end
    if (!sub_v[NUM_W]) begin
      data_d.rem_v      = sub_v[NUM_W-1:0];
      data_d.q_v[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/vertex_normal_tangent_packer_top.sv -----
// Vertex normal and tangent packer: 10:10:10 snorm normal and 8:8 octahedral tangent.
// Depends on vntp_pkg and vntp_div_stage.
//
// Takes one vertex beat per cycle while the output is not stalled and returns
// one packed beat per vertex, in order. The seven-step restoring divider
// that rounds the two octahedral coordinates, one quotient bit per stage,
// sits behind three stages of normal quantisation and tangent projection. A
// stall on the output while a beat is held there freezes the whole pipeline
// and is passed straight back to the input.
module vertex_normal_tangent_packer_top #(
  parameter int unsigned FRACTION_BITS = vntp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [vntp_pkg::COMP_W-1:0]  normal_x_i,
  input  logic signed [vntp_pkg::COMP_W-1:0]  normal_y_i,
  input  logic signed [vntp_pkg::COMP_W-1:0]  normal_z_i,
  input  logic signed [vntp_pkg::COMP_W-1:0]  tangent_x_i,
  input  logic signed [vntp_pkg::COMP_W-1:0]  tangent_y_i,
  input  logic signed [vntp_pkg::COMP_W-1:0]  tangent_z_i,
  input  logic                                tangent_w_negative_i,
  input  logic                                has_normal_i,
  input  logic                                has_tangent_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [30:0]                         normal_word_o,
  output logic [15:0]                         tangent_word_o
);
  import vntp_pkg::*;

  localparam int unsigned PW = ((FRACTION_BITS > 16) ? FRACTION_BITS : 16) + 11;
  localparam logic [PW-1:0] ONE  = PW'(1) << FRACTION_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

  function automatic logic [9:0] quant_n(logic [COMP_W-1:0] n);
    logic [COMP_W:0] a;
    logic [PW-1:0]   m;
    logic [PW-1:0]   p;
    logic [8:0]      mag;
    a = n[COMP_W-1] ? (COMP_W+1)'(-{1'b1, n}) : {1'b0, n};
    m = PW'(a);
    if (m > ONE) begin
      m = ONE;
    end
    p   = (m << 9) - m + HALF;
    mag = p[FRACTION_BITS +: 9];
    return n[COMP_W-1] ? NORM_BIAS - 10'(mag) : NORM_BIAS + 10'(mag);
  endfunction

  function automatic logic [COMP_W-1:0] abs16(logic [COMP_W-1:0] n);
    return n[COMP_W-1] ? (~n + COMP_W'(1)) : n;
  endfunction

  function automatic logic [7:0] oct_bias(logic neg, logic [OCT_Q_W-1:0] mag);
    return neg ? OCT_BIAS - 8'(mag) : OCT_BIAS + 8'(mag);
  endfunction

  logic en;

  // stage 1: normal quantisation, tangent magnitudes
  logic              s1_vld_q;
  logic [29:0]       s1_nbits_q;
  logic              s1_flag_q, s1_has_t_q, s1_zneg_q, s1_neg_u_q, s1_neg_v_q;
  logic [COMP_W-1:0] s1_ax_q, s1_ay_q, s1_az_q;
  logic [29:0]       s1_nbits_d;

  // stage 2: projection sums
  logic              s2_vld_q;
  logic [29:0]       s2_nbits_q;
  logic              s2_flag_q, s2_tzero_q, s2_neg_u_q, s2_neg_v_q;
  logic [TSUM_W-1:0] s2_tsum_q, s2_mu_q, s2_mv_q;
  logic [TSUM_W-1:0] s2_tsum_d, s2_mu_d, s2_mv_d;

  // stage 3: dividend and divisor
  logic              s3_vld_q;
  vntp_div_t         s3_q, s3_d;

  logic              dv_vld [DIV_STEPS+1];
  vntp_div_t         dv_dat [DIV_STEPS+1];

  logic              out_vld_q;
  logic [30:0]       out_nword_q;
  logic [15:0]       out_tword_q;
  logic [15:0]       out_tword_d;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  always_comb begin
    s1_nbits_d = '0;
    if (has_normal_i) begin
      s1_nbits_d = {quant_n(normal_z_i), quant_n(normal_y_i), quant_n(normal_x_i)};
    end
  end

  always_comb begin
    s2_tsum_d = TSUM_W'(s1_ax_q) + TSUM_W'(s1_ay_q) + TSUM_W'(s1_az_q);
    s2_mu_d   = s1_zneg_q ? TSUM_W'(s1_ax_q) + TSUM_W'(s1_az_q) : TSUM_W'(s1_ax_q);
    s2_mv_d   = s1_zneg_q ? TSUM_W'(s1_ay_q) + TSUM_W'(s1_az_q) : TSUM_W'(s1_ay_q);
  end

  always_comb begin
    s3_d.nbits = s2_nbits_q;
    s3_d.flag  = s2_flag_q;
    s3_d.tzero = s2_tzero_q;
    s3_d.neg_u = s2_neg_u_q;
    s3_d.neg_v = s2_neg_v_q;
    s3_d.rem_u = (NUM_W'(s2_mu_q) << 8) - (NUM_W'(s2_mu_q) << 1) + NUM_W'(s2_tsum_q);
    s3_d.rem_v = (NUM_W'(s2_mv_q) << 8) - (NUM_W'(s2_mv_q) << 1) + NUM_W'(s2_tsum_q);
    s3_d.den   = {s2_tsum_q, 1'b0};
    s3_d.q_u   = '0;
    s3_d.q_v   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_nbits_q <= s1_nbits_d;
      s1_flag_q  <= has_tangent_i && tangent_w_negative_i;
      s1_has_t_q <= has_tangent_i;
      s1_zneg_q  <= tangent_z_i[COMP_W-1];
      s1_neg_u_q <= tangent_x_i[COMP_W-1];
      s1_neg_v_q <= tangent_y_i[COMP_W-1];
      s1_ax_q    <= abs16(tangent_x_i);
      s1_ay_q    <= abs16(tangent_y_i);
      s1_az_q    <= abs16(tangent_z_i);

      s2_nbits_q <= s1_nbits_q;
      s2_flag_q  <= s1_flag_q;
      s2_tzero_q <= !s1_has_t_q || (s2_tsum_d == '0);
      s2_neg_u_q <= s1_neg_u_q;
      s2_neg_v_q <= s1_neg_v_q;
      s2_tsum_q  <= s2_tsum_d;
      s2_mu_q    <= s2_mu_d;
      s2_mv_q    <= s2_mv_d;

      s3_q <= s3_d;

      out_nword_q <= {dv_dat[DIV_STEPS].flag, dv_dat[DIV_STEPS].nbits};
      out_tword_q <= out_tword_d;
    end
  end

  assign dv_vld[0] = s3_vld_q;
  assign dv_dat[0] = s3_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    vntp_div_stage #(
      .SHIFT(DIV_STEPS - 1 - i)
    ) u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[i]),
      .data_i (dv_dat[i]),
      .vld_o  (dv_vld[i+1]),
      .data_o (dv_dat[i+1])
    );
  end

  always_comb begin
    out_tword_d = '0;
    if (!dv_dat[DIV_STEPS].tzero) begin
      out_tword_d = {oct_bias(dv_dat[DIV_STEPS].neg_v, dv_dat[DIV_STEPS].q_v),
                     oct_bias(dv_dat[DIV_STEPS].neg_u, dv_dat[DIV_STEPS].q_u)};
    end
  end

  assign valid_o        = out_vld_q;
  assign normal_word_o  = out_nword_q;
  assign tangent_word_o = out_tword_q;

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for vertex_normal_tangent_packer_top: snorm 10:10:10 normal
// and 8:8 octahedral tangent, predicted per beat and checked in order.
// Depends on vntp_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
  import vntp_pkg::*;

  localparam int unsigned FB       = FRACTION_BITS_DEF;
  localparam int          N_RANDOM = 1200;
  localparam int          WD_LIMIT = 4000;

  typedef struct packed {
    logic signed [COMP_W-1:0] nx, ny, nz, tx, ty, tz;
    logic                     wneg, has_n, has_t;
    logic                     wait_drain;
  } vertex_t;

  typedef struct packed {
    logic [30:0] nword;
    logic [15:0] tword;
  } packed_t;

  logic                     clk_i                = 1'b0;
  logic                     rst_ni               = 1'b0;
  logic                     valid_i              = 1'b0;
  logic                     stall_o;
  logic signed [COMP_W-1:0] normal_x_i           = '0;
  logic signed [COMP_W-1:0] normal_y_i           = '0;
  logic signed [COMP_W-1:0] normal_z_i           = '0;
  logic signed [COMP_W-1:0] tangent_x_i          = '0;
  logic signed [COMP_W-1:0] tangent_y_i          = '0;
  logic signed [COMP_W-1:0] tangent_z_i          = '0;
  logic                     tangent_w_negative_i = 1'b0;
  logic                     has_normal_i         = 1'b0;
  logic                     has_tangent_i        = 1'b0;
  logic                     valid_o;
  logic                     stall_i              = 1'b0;
  logic [30:0]              normal_word_o;
  logic [15:0]              tangent_word_o;

  vertex_t vertex_q[$];
  packed_t packed_q[$];
  int      n_sent    = 0;
  int      bad_beats = 0;
  int      quiet_cyc = 0;
  int      send_idle = 37;
  int      recv_idle = 66;

  vertex_normal_tangent_packer_top #(
    .FRACTION_BITS(FB)
  ) dut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .normal_x_i,
    .normal_y_i,
    .normal_z_i,
    .tangent_x_i,
    .tangent_y_i,
    .tangent_z_i,
    .tangent_w_negative_i,
    .has_normal_i,
    .has_tangent_i,
    .valid_o,
    .stall_i,
    .normal_word_o,
    .tangent_word_o
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [9:0] snorm10(input longint n);
    longint lim, mag, q;
    lim = longint'(1) << FB;
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
    mag = ((n < 0 ? -n : n) * longint'(NORM_BIAS) + (longint'(1) << (FB - 1))) / lim;
    q = (n < 0) ? -mag : mag;
    return 10'(q + longint'(NORM_BIAS));
  endfunction

  function automatic logic [7:0] snorm8_oct(input longint m, input logic neg,
                                           input longint tsum);
    longint mag, q;
    mag = (2 * m * longint'(OCT_BIAS) + tsum) / (2 * tsum);
    q = neg ? -mag : mag;
    return 8'(q + longint'(OCT_BIAS));
  endfunction

  function automatic packed_t pack_vertex(input vertex_t v);
    packed_t r;
    longint  ax, ay, az, tsum, mu, mv;
    r = '0;
    if (v.has_n)
      r.nword[29:0] = {snorm10(longint'(v.nz)), snorm10(longint'(v.ny)),
                       snorm10(longint'(v.nx))};
    if (v.has_t) begin
      ax = (v.tx < 0) ? -longint'(v.tx) : longint'(v.tx);
      ay = (v.ty < 0) ? -longint'(v.ty) : longint'(v.ty);
      az = (v.tz < 0) ? -longint'(v.tz) : longint'(v.tz);
      tsum = ax + ay + az;
      r.nword[30] = v.wneg;
      if (tsum != 0) begin
        if (v.tz >= 0) begin
          mu = ax;
          mv = ay;
        end else begin
          mu = tsum - ay;
          mv = tsum - ax;
        end
        r.tword = {snorm8_oct(mv, v.ty < 0, tsum), snorm8_oct(mu, v.tx < 0, tsum)};
      end
    end
    return r;
  endfunction

  task automatic add_vertex(input int nx, ny, nz, tx, ty, tz,
                            input bit wneg, has_n, has_t);
    vertex_t v;
    v = '{nx: 16'(nx), ny: 16'(ny), nz: 16'(nz), tx: 16'(tx), ty: 16'(ty),
          tz: 16'(tz), wneg: wneg, has_n: has_n, has_t: has_t, wait_drain: 1'b0};
    vertex_q.push_back(v);
  endtask

  // mix of full-range, near-unit and tiny components
  function automatic int rand_comp(input int kind);
    case (kind)
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(34816) - 17408;
      2: return $urandom_range(600) - 300;
      default: return ($urandom_range(3) == 0) ? 0 : $urandom_range(40000) - 20000;
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t nxt;
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else begin
      if (valid_i && !stall_o) begin
        packed_q.push_back(pack_vertex('{nx: normal_x_i, ny: normal_y_i, nz: normal_z_i,
                                         tx: tangent_x_i, ty: tangent_y_i,
                                         tz: tangent_z_i, wneg: tangent_w_negative_i,
                                         has_n: has_normal_i, has_t: has_tangent_i,
                                         wait_drain: 1'b0}));
        n_sent++;
      end
      if (!valid_i || !stall_o) begin
        if (vertex_q.size() != 0 && !(vertex_q[0].wait_drain && packed_q.size() != 0) &&
            $urandom_range(99) >= send_idle) begin
          nxt = vertex_q.pop_front();
          valid_i              <= 1'b1;
          normal_x_i           <= nxt.nx;
          normal_y_i           <= nxt.ny;
          normal_z_i           <= nxt.nz;
          tangent_x_i          <= nxt.tx;
          tangent_y_i          <= nxt.ty;
          tangent_z_i          <= nxt.tz;
          tangent_w_negative_i <= nxt.wneg;
          has_normal_i         <= nxt.has_n;
          has_tangent_i        <= nxt.has_t;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    packed_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (packed_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected beat: normal %h tangent %h", normal_word_o, tangent_word_o);
        end else begin
          want = packed_q.pop_front();
          if (normal_word_o !== want.nword || tangent_word_o !== want.tword) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("mismatch: normal exp %h got %h, tangent exp %h got %h",
                       want.nword, normal_word_o, want.tword, tangent_word_o);
          end
        end
      end
      stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= WD_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin
    int kind, i;
    // extremes, saturation and rounding
    add_vertex(32767, -32768, 0, 32767, -32768, 0, 1'b0, 1'b1, 1'b1);
    add_vertex(-32768, 32767, -1, -32768, 32767, -32768, 1'b1, 1'b1, 1'b1);
    add_vertex(16384, -16384, 16385, 16384, 0, 0, 1'b0, 1'b1, 1'b1);
    add_vertex(-16385, 16383, -16383, 0, -16384, 0, 1'b1, 1'b1, 1'b1);
    add_vertex(16, -16, 48, 1, 253, 0, 1'b0, 1'b1, 1'b1);
    add_vertex(0, 0, 0, -1, -253, 0, 1'b0, 1'b1, 1'b1);
    // zero tangent
    add_vertex(100, 200, 300, 0, 0, 0, 1'b1, 1'b1, 1'b1);
    add_vertex(-100, 0, 5, 0, 0, 0, 1'b0, 1'b1, 1'b1);
    // negative z hemisphere, zeros counted as positive
    add_vertex(1, 2, 3, 0, 0, -16384, 1'b0, 1'b1, 1'b1);
    add_vertex(1, 2, 3, 0, 5000, -3000, 1'b1, 1'b1, 1'b1);
    add_vertex(1, 2, 3, -7000, 0, -1, 1'b0, 1'b1, 1'b1);
    add_vertex(1, 2, 3, -5461, 5461, -5462, 1'b1, 1'b1, 1'b1);
    // absent normal / tangent, handedness without normal
    add_vertex(12345, -12345, 777, 300, 400, 500, 1'b1, 1'b0, 1'b1);
    add_vertex(12345, -12345, 777, 300, 400, 500, 1'b0, 1'b0, 1'b1);
    add_vertex(12345, -12345, 777, 300, 400, -500, 1'b1, 1'b1, 1'b0);
    add_vertex(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 1'b0, 1'b0);
    add_vertex(-1, 1, -2, 0, 0, 0, 1'b1, 1'b0, 1'b1);
    add_vertex(32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 1'b1, 1'b1);

    for (i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(3);
      add_vertex(rand_comp(kind), rand_comp(kind), rand_comp(kind),
                 rand_comp(kind), rand_comp(kind), rand_comp(kind),
                 $urandom_range(1), $urandom_range(9) != 0, $urandom_range(9) != 0);
      if (i == 300 || i == 900)
        vertex_q[$].wait_drain = 1'b1;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < 420) @(posedge clk_i);
    send_idle <= 66;
    recv_idle <= 37;
    while (n_sent < 840) @(posedge clk_i);
    send_idle <= 0;
    recv_idle <= 0;

    do @(posedge clk_i);
    while (vertex_q.size() != 0 || valid_i || packed_q.size() != 0);
    repeat (20) @(posedge clk_i);

    if (bad_beats == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
